@@ design/cpuio_pkg.sv @@
// Shared types and constants for the CPU I/O register decoder.
package cpuio_pkg;

	// Bus action codes carried by each transaction.
	typedef enum logic [1:0] {
		ACT_READ  = 2'd0,
		ACT_WRITE = 2'd1,
		ACT_TICK  = 2'd2,
		ACT_NONE  = 2'd3
	} action_t;

	// Picture-unit access events.
	localparam logic [3:0] PEV_NONE       = 4'd0;
	localparam logic [3:0] PEV_CTRL_WR    = 4'd1;
	localparam logic [3:0] PEV_STATUS_RD  = 4'd2;
	localparam logic [3:0] PEV_SCROLL_WR  = 4'd3;
	localparam logic [3:0] PEV_OAM_RD     = 4'd4;
	localparam logic [3:0] PEV_OAM_WR     = 4'd5;
	localparam logic [3:0] PEV_ADDR_WR    = 4'd6;
	localparam logic [3:0] PEV_DATA_RD    = 4'd7;
	localparam logic [3:0] PEV_DATA_WR    = 4'd8;

	// Picture-unit register offsets within each 8-byte mirror.
	localparam logic [2:0] PREG_CTRL   = 3'd0;
	localparam logic [2:0] PREG_STATUS = 3'd2;
	localparam logic [2:0] PREG_OAM    = 3'd4;
	localparam logic [2:0] PREG_SCROLL = 3'd5;
	localparam logic [2:0] PREG_ADDR   = 3'd6;
	localparam logic [2:0] PREG_DATA   = 3'd7;

	// I/O register addresses.
	localparam logic [15:0] ADDR_SOUND_BASE = 16'h4000;
	localparam logic [15:0] ADDR_DMA        = 16'h4014;
	localparam logic [15:0] ADDR_STATUS     = 16'h4015;
	localparam logic [15:0] ADDR_PAD1       = 16'h4016;
	localparam logic [15:0] ADDR_PAD2       = 16'h4017;
	localparam logic [4:0]  SOUND_REG_COUNT = 5'd20;

	// Sound index value that means no sound register was written.
	localparam logic [4:0]  NO_SOUND_WRITE  = 5'd20;

endpackage

@@ design/console_cpu_io_register_decode.sv @@
// CPU I/O register decoder: picture, sound, status, DMA, frame counter and joypads.
//
// Usage:
// Each input transaction is one CPU bus read, one bus write, or the tick at
// the end of an instruction, together with the live status inputs (channel
// activity, picture flags, button bytes, interrupt raise requests). Every
// input transaction yields exactly one result transaction that carries the
// read data, the decoded access events and the stored register values after
// that access.
// An accepted transaction is captured in the input register and is decoded
// into the result register as it leaves. Throughput is one transaction per
// cycle while the receiver does not stall, set by the single pass of decode
// logic between the two registers; state is updated as the item leaves the
// input register.
// The result register frees the input side: a new transaction is taken while
// the previous result still waits, as long as the input register can move.
// When the receiver stalls, the result holds and the input register fills,
// after which in_ready drops until the result is taken.
// Reset clears all stored registers (joypad shifters, interrupt flags, frame
// mode, channel enables, DMA page) and empties both pipeline registers.
module console_cpu_io_register_decode
	import cpuio_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [1:0]  action,
	input  logic [15:0] address,
	input  logic [7:0]  write_data,
	input  logic [4:0]  channel_active,
	input  logic [2:0]  picture_status_flags,
	input  logic [7:0]  pad1_buttons,
	input  logic [7:0]  pad2_buttons,
	input  logic [1:0]  irq_raise,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [7:0]  read_data,
	output logic [3:0]  picture_event,
	output logic [4:0]  sound_write_index,
	output logic [4:0]  channel_enable,
	output logic        sample_restart,
	output logic        sprite_dma_start,
	output logic [7:0]  sprite_dma_page,
	output logic        frame_mode,
	output logic        frame_restart,
	output logic        irq_pending,
	output logic        pad1_bit,
	output logic        pad2_bit
);

	// Input register.
	logic        valid_s1;
	logic [1:0]  action_s1;
	logic [15:0] address_s1;
	logic [7:0]  wdata_s1;
	logic [4:0]  active_s1;
	logic [2:0]  pflags_s1;
	logic [7:0]  b1_s1;
	logic [7:0]  b2_s1;
	logic [1:0]  raise_s1;

	// Architectural state.
	logic [7:0]  pad1_shift_q, pad2_shift_q;
	logic        pad1_out_q, pad2_out_q, pad_strobe_q;
	logic        frame_irq_q, sample_irq_q;
	logic        frame_mode_q, frame_inhibit_q;
	logic [4:0]  enable_q;
	logic [7:0]  dma_page_q;

	// Result register.
	logic        out_valid_q;
	logic [7:0]  rd_q;
	logic [3:0]  pev_q;
	logic [4:0]  snd_q;
	logic        restart_q, dma_go_q, frestart_q;

	// Next-state and result values from the decode.
	logic [7:0]  pad1_shift_d, pad2_shift_d;
	logic        pad1_out_d, pad2_out_d, pad_strobe_d;
	logic        frame_irq_d, sample_irq_d;
	logic        frame_mode_d, frame_inhibit_d;
	logic [4:0]  enable_d;
	logic [7:0]  dma_page_d;
	logic [7:0]  rd_d;
	logic [3:0]  pev_d;
	logic [4:0]  snd_d;
	logic        restart_d, dma_go_d, frestart_d;
	logic        is_read, is_write, is_access, is_picture, is_sound;

	// Pipeline advance: results move out when the result register is free.
	logic adv_s2, adv_s1;
	assign adv_s2   = !out_valid_q || out_ready;
	assign adv_s1   = valid_s1 && adv_s2;
	assign in_ready = !valid_s1 || adv_s2;

	// Input register capture.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			action_s1  <= action;
			address_s1 <= address;
			wdata_s1   <= write_data;
			active_s1  <= channel_active;
			pflags_s1  <= picture_status_flags;
			b1_s1      <= pad1_buttons;
			b2_s1      <= pad2_buttons;
			raise_s1   <= irq_raise;
		end
	end

	// Address decode of the held access.
	assign is_read    = (action_s1 == ACT_READ);
	assign is_write   = (action_s1 == ACT_WRITE);
	assign is_access  = is_read || is_write;
	assign is_picture = (address_s1[15:13] == 3'b001);
	assign is_sound   = (address_s1[15:5] == ADDR_SOUND_BASE[15:5])
		&& (address_s1[4:0] < SOUND_REG_COUNT);

	// Register access and tick behavior.
	always_comb begin
		pad1_shift_d    = pad1_shift_q;
		pad2_shift_d    = pad2_shift_q;
		pad1_out_d      = pad1_out_q;
		pad2_out_d      = pad2_out_q;
		pad_strobe_d    = pad_strobe_q;
		frame_irq_d     = frame_irq_q;
		sample_irq_d    = sample_irq_q;
		frame_mode_d    = frame_mode_q;
		frame_inhibit_d = frame_inhibit_q;
		enable_d        = enable_q;
		dma_page_d      = dma_page_q;
		rd_d            = 8'h00;
		pev_d           = PEV_NONE;
		snd_d           = NO_SOUND_WRITE;
		restart_d       = 1'b0;
		dma_go_d        = 1'b0;
		frestart_d      = 1'b0;

		if (is_access) begin
			if (is_picture) begin
				case (address_s1[2:0])
					PREG_CTRL: begin
						pev_d = is_write ? PEV_CTRL_WR : PEV_NONE;
					end
					PREG_STATUS: begin
						if (is_read) begin
							pev_d = PEV_STATUS_RD;
							rd_d  = {pflags_s1, 5'b00000};
						end
					end
					PREG_OAM: begin
						pev_d = is_write ? PEV_OAM_WR : PEV_OAM_RD;
					end
					PREG_SCROLL: begin
						pev_d = is_write ? PEV_SCROLL_WR : PEV_NONE;
					end
					PREG_ADDR: begin
						pev_d = is_write ? PEV_ADDR_WR : PEV_NONE;
					end
					PREG_DATA: begin
						pev_d = is_write ? PEV_DATA_WR : PEV_DATA_RD;
					end
					default: begin
						pev_d = PEV_NONE;
					end
				endcase
			end else if (is_sound) begin
				if (is_write) begin
					snd_d = address_s1[4:0];
				end
			end else if (address_s1 == ADDR_STATUS) begin
				if (is_write) begin
					enable_d     = wdata_s1[4:0];
					sample_irq_d = 1'b0;
					restart_d    = wdata_s1[4];
				end else begin
					rd_d        = {sample_irq_q, frame_irq_q, 1'b0, active_s1};
					frame_irq_d = 1'b0;
				end
			end else if (address_s1 == ADDR_DMA) begin
				if (is_write) begin
					dma_page_d = wdata_s1;
					dma_go_d   = 1'b1;
				end
			end else if (address_s1 == ADDR_PAD1) begin
				if (is_write) begin
					pad_strobe_d = wdata_s1[0];
				end else begin
					rd_d         = {7'b0000000, pad1_out_q};
					pad1_shift_d = {1'b1, pad1_shift_q[7:1]};
				end
			end else if (address_s1 == ADDR_PAD2) begin
				if (is_write) begin
					frame_mode_d    = wdata_s1[7];
					frame_inhibit_d = wdata_s1[6];
					if (wdata_s1[6]) begin
						frame_irq_d = 1'b0;
					end
					frestart_d = 1'b1;
				end else begin
					rd_d         = {7'b0000000, pad2_out_q};
					pad2_shift_d = {1'b1, pad2_shift_q[7:1]};
				end
			end
		end else if (action_s1 == ACT_TICK) begin
			// Raise interrupts, reload joypads while strobed, present bit 0.
			if (raise_s1[0] && !frame_inhibit_q) begin
				frame_irq_d = 1'b1;
			end
			if (raise_s1[1]) begin
				sample_irq_d = 1'b1;
			end
			if (pad_strobe_q) begin
				pad1_shift_d = b1_s1;
				pad2_shift_d = b2_s1;
			end
			pad1_out_d = pad1_shift_d[0];
			pad2_out_d = pad2_shift_d[0];
		end
	end

	// State update as the item leaves the input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pad1_shift_q    <= 8'h00;
			pad2_shift_q    <= 8'h00;
			pad1_out_q      <= 1'b0;
			pad2_out_q      <= 1'b0;
			pad_strobe_q    <= 1'b0;
			frame_irq_q     <= 1'b0;
			sample_irq_q    <= 1'b0;
			frame_mode_q    <= 1'b0;
			frame_inhibit_q <= 1'b0;
			enable_q        <= 5'b00000;
			dma_page_q      <= 8'h00;
			out_valid_q     <= 1'b0;
		end else begin
			if (adv_s1) begin
				pad1_shift_q    <= pad1_shift_d;
				pad2_shift_q    <= pad2_shift_d;
				pad1_out_q      <= pad1_out_d;
				pad2_out_q      <= pad2_out_d;
				pad_strobe_q    <= pad_strobe_d;
				frame_irq_q     <= frame_irq_d;
				sample_irq_q    <= sample_irq_d;
				frame_mode_q    <= frame_mode_d;
				frame_inhibit_q <= frame_inhibit_d;
				enable_q        <= enable_d;
				dma_page_q      <= dma_page_d;
			end
			if (adv_s2) begin
				out_valid_q <= valid_s1;
			end
		end
	end

	// Per-access result fields.
	always_ff @(posedge clk) begin
		if (adv_s1) begin
			rd_q       <= rd_d;
			pev_q      <= pev_d;
			snd_q      <= snd_d;
			restart_q  <= restart_d;
			dma_go_q   <= dma_go_d;
			frestart_q <= frestart_d;
		end
	end

	// Stored registers already hold the values after the last delivered
	// access, since the next state is only written as its result is loaded.
	assign out_valid         = out_valid_q;
	assign read_data         = rd_q;
	assign picture_event     = pev_q;
	assign sound_write_index = snd_q;
	assign channel_enable    = enable_q;
	assign sample_restart    = restart_q;
	assign sprite_dma_start  = dma_go_q;
	assign sprite_dma_page   = dma_page_q;
	assign frame_mode        = frame_mode_q;
	assign frame_restart     = frestart_q;
	assign irq_pending       = frame_irq_q || sample_irq_q;
	assign pad1_bit          = pad1_out_q;
	assign pad2_bit          = pad2_out_q;

endmodule

@@ design/cpuio_checker.sv @@
// Port-level checker for the CPU I/O register decoder, with its bind.
module cpuio_checker
	import cpuio_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        out_valid,
	input  logic        out_ready,
	input  logic [7:0]  read_data,
	input  logic [3:0]  picture_event,
	input  logic [4:0]  sound_write_index,
	input  logic [4:0]  channel_enable,
	input  logic        sample_restart,
	input  logic        sprite_dma_start,
	input  logic        frame_restart
);

	// A stalled result transaction keeps its data.
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(read_data)
			&& $stable(picture_event))
		else $error("result changed while stalled");

	// A sample restart comes from a status write, which stores bit 4 as set.
	a_restart_enable: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && sample_restart |-> channel_enable[4])
		else $error("sample restart without sample enable");

	// A frame counter write is no picture or sound access and returns no data.
	a_frame_exclusive: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && frame_restart |-> picture_event == PEV_NONE
			&& sound_write_index == NO_SOUND_WRITE && read_data == 8'h00)
		else $error("frame counter write overlaps another decode");

	// A sprite DMA trigger is a write: no read data and no other event.
	a_dma_exclusive: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && sprite_dma_start |-> read_data == 8'h00
			&& !frame_restart && !sample_restart)
		else $error("sprite DMA trigger overlaps another decode");

endmodule

bind console_cpu_io_register_decode cpuio_checker u_cpuio_checker (.*);
